[src/arut_pkg.sv]
// Shared types and codes for the address region table.
`timescale 1ns / 1ps
`default_nettype none
package arut_pkg;

    typedef struct packed {
        logic        mode;
        logic [31:0] address;
        logic [31:0] length;
        logic [15:0] backer_id;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot;
        logic [31:0] region_start;
        logic [32:0] region_size;
        logic [15:0] region_backer;
    } out_item_t;

    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_FIND = 1'b1;

    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_OVERLAP  = 3'd1;
    localparam logic [2:0] STAT_FULL     = 3'd2;
    localparam logic [2:0] STAT_NOTFOUND = 3'd3;
    localparam logic [2:0] STAT_BADRANGE = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic issue;
        logic finish;
    } ctrl_cmd_t;

endpackage
`default_nettype wire

[src/address_region_table_top.sv]
// Top level of the address region table: controller plus datapath.
// A new request is taken only after the previous one has finished; its scan reads one
// table entry per cycle through the single memory read port.
// The result register frees the input side: a new request is taken while a result waits.
// Reset clears all entry valid bits at once; entry contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module address_region_table_top #(
    parameter int TABLE_ENTRIES = 16,
    parameter int PAGE_BITS     = 12,
    parameter int ADDR_BITS     = 32
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  req_valid,
    output logic                 req_stall,
    input  wire arut_pkg::in_item_t req,
    output logic                 rsp_valid,
    input  wire                  rsp_stall,
    output arut_pkg::out_item_t  rsp
);
    import arut_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    ctrl_cmd_t     cmd;
    logic [IW-1:0] idx;

    arut_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IW            (IW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .idx       (idx)
    );

    arut_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .PAGE_BITS     (PAGE_BITS),
        .ADDR_BITS     (ADDR_BITS),
        .IW            (IW)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .idx   (idx),
        .rsp   (rsp)
    );

endmodule
`default_nettype wire

[src/arut_ctrl.sv]
// Controller: sequences the table scan and owns both handshakes.
`timescale 1ns / 1ps
`default_nettype none
module arut_ctrl #(
    parameter int TABLE_ENTRIES = 16,
    parameter int IW            = 4
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  req_valid,
    output logic                 req_stall,
    output logic                 rsp_valid,
    input  wire                  rsp_stall,
    output arut_pkg::ctrl_cmd_t  cmd,
    output logic [IW-1:0]        idx
);
    import arut_pkg::*;

    ctrl_state_t   state_reg, state_next;
    logic [IW-1:0] cnt_reg, cnt_next;
    logic          rsp_valid_reg, rsp_valid_next;
    logic          last_entry;
    logic          out_free;

    assign last_entry = (cnt_reg == IW'(TABLE_ENTRIES - 1));
    assign out_free   = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        cmd            = '0;
        req_stall      = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
                cnt_next  = cnt_reg + IW'(1);
                if (last_entry)
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // let the last read entry reach the compare stage
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hold until the result register is free
                if (out_free)
                begin
                    cmd.finish     = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign idx       = cnt_reg;
    assign rsp_valid = rsp_valid_reg;

`ifndef SYNTHESIS
    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg == ST_SCAN && cnt_reg == '0))
        else $error("accepted request did not start a scan at entry zero");

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> req_stall)
        else $error("request taken while a scan is in progress");

    a_finish_posts_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (rsp_valid && state_reg == ST_IDLE))
        else $error("finished request did not post a result");
`endif

endmodule
`default_nettype wire

[src/arut_dp.sv]
// Datapath: region table memory, request registers, compare stage and result register.
`timescale 1ns / 1ps
`default_nettype none
module arut_dp #(
    parameter int TABLE_ENTRIES = 16,
    parameter int PAGE_BITS     = 12,
    parameter int ADDR_BITS     = 32,
    parameter int IW            = 4
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire arut_pkg::in_item_t  req,
    input  wire arut_pkg::ctrl_cmd_t cmd,
    input  wire [IW-1:0]         idx,
    output arut_pkg::out_item_t  rsp
);
    import arut_pkg::*;

    localparam int SPW   = ADDR_BITS - PAGE_BITS;
    localparam int CPW   = 33 - PAGE_BITS;
    localparam int EW    = ((SPW > CPW) ? SPW : CPW) + 1;
    localparam int EBITS = SPW + CPW + 16;
    localparam logic [EW-1:0] SPACE_PAGES = {{(EW-1){1'b0}}, 1'b1} << SPW;

    // request decode
    logic [ADDR_BITS+31:0] addr_ext;
    logic [ADDR_BITS-1:0]  addr_in;
    logic [SPW-1:0]        page_in;
    logic [32:0]           len_round;
    logic [CPW-1:0]        pages_in;
    logic [EW-1:0]         end_in;
    logic                  bad_in;

    assign addr_ext  = {32'd0, req.address};
    assign addr_in   = addr_ext[ADDR_BITS-1:0];
    assign page_in   = addr_in[ADDR_BITS-1:PAGE_BITS];
    assign len_round = {1'b0, req.length} + 33'((64'd1 << PAGE_BITS) - 64'd1);
    assign pages_in  = len_round[32:PAGE_BITS];
    assign end_in    = EW'(page_in) + EW'(pages_in);
    assign bad_in    = (req.length == 32'd0) || (end_in > SPACE_PAGES);

    logic                     mode_reg;
    logic [SPW-1:0]           key_reg;
    logic [CPW-1:0]           pages_reg;
    logic [EW-1:0]            end_reg;
    logic [15:0]              backer_reg;
    logic                     bad_reg;

    logic [EBITS-1:0]         mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;

    logic                     rd_en_reg;
    logic                     rd_valid_reg;
    logic [IW-1:0]            rd_idx_reg;
    logic [EBITS-1:0]         rd_entry_reg;

    logic                     hit_reg;
    logic [IW-1:0]            hit_idx_reg;
    logic [EBITS-1:0]         hit_entry_reg;
    logic                     free_found_reg;
    logic [IW-1:0]            free_idx_reg;

    out_item_t                rsp_reg;

    // compare stage
    logic [SPW-1:0] rd_start;
    logic [CPW-1:0] rd_count;
    logic [EW-1:0]  e_start, e_end, key_w;
    logic           overlaps, holds, match, is_free;

    assign rd_start = rd_entry_reg[EBITS-1 -: SPW];
    assign rd_count = rd_entry_reg[CPW+15:16];
    assign e_start  = EW'(rd_start);
    assign e_end    = e_start + EW'(rd_count);
    assign key_w    = EW'(key_reg);
    assign overlaps = (key_w < e_end) && (e_start < end_reg);
    assign holds    = (e_start <= key_w) && (key_w < e_end);
    assign match    = rd_en_reg && rd_valid_reg && ((mode_reg == MODE_FIND) ? holds : overlaps);
    assign is_free  = rd_en_reg && !rd_valid_reg;

    // result selection
    logic [2:0]            res_status;
    logic                  res_write;
    logic [IW-1:0]         sel_idx;
    logic [SPW-1:0]        sel_page;
    logic [CPW-1:0]        sel_count;
    logic [15:0]           sel_backer;
    logic [ADDR_BITS-1:0]  start_full;
    logic [ADDR_BITS+31:0] start_ext;
    logic [IW+3:0]         slot_ext;

    always_comb
    begin
        res_status = STAT_OK;
        res_write  = 1'b0;
        sel_idx    = free_idx_reg;
        sel_page   = key_reg;
        sel_count  = pages_reg;
        sel_backer = backer_reg;
        if (mode_reg == MODE_ADD)
        begin
            if (bad_reg)
                res_status = STAT_BADRANGE;
            else if (hit_reg)
                res_status = STAT_OVERLAP;
            else if (!free_found_reg)
                res_status = STAT_FULL;
            else
                res_write = 1'b1;
        end
        else
        begin
            sel_idx    = hit_idx_reg;
            sel_page   = hit_entry_reg[EBITS-1 -: SPW];
            sel_count  = hit_entry_reg[CPW+15:16];
            sel_backer = hit_entry_reg[15:0];
            if (!hit_reg)
                res_status = STAT_NOTFOUND;
        end
    end

    assign start_full = {sel_page, {PAGE_BITS{1'b0}}};
    assign start_ext  = {32'd0, start_full};
    assign slot_ext   = {4'd0, sel_idx};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            rd_en_reg      <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            rd_en_reg <= cmd.issue;
            if (cmd.load)
            begin
                hit_reg        <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else
            begin
                // keep the lowest-numbered hit and free slot
                if (match && !hit_reg)
                    hit_reg <= 1'b1;
                if (is_free && !free_found_reg)
                    free_found_reg <= 1'b1;
            end
            if (cmd.finish && res_write)
                valid_reg[free_idx_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg   <= req.mode;
            key_reg    <= page_in;
            pages_reg  <= pages_in;
            end_reg    <= end_in;
            backer_reg <= req.backer_id;
            bad_reg    <= bad_in;
        end
        if (cmd.issue)
        begin
            rd_idx_reg   <= idx;
            rd_valid_reg <= valid_reg[idx];
        end
        if (match && !hit_reg)
        begin
            hit_idx_reg   <= rd_idx_reg;
            hit_entry_reg <= rd_entry_reg;
        end
        if (is_free && !free_found_reg)
            free_idx_reg <= rd_idx_reg;
        if (cmd.finish)
        begin
            rsp_reg.status <= res_status;
            if (res_status == STAT_OK)
            begin
                rsp_reg.slot          <= slot_ext[3:0];
                rsp_reg.region_start  <= start_ext[31:0];
                rsp_reg.region_size   <= {sel_count, {PAGE_BITS{1'b0}}};
                rsp_reg.region_backer <= sel_backer;
            end
            else
            begin
                rsp_reg.slot          <= '0;
                rsp_reg.region_start  <= '0;
                rsp_reg.region_size   <= '0;
                rsp_reg.region_backer <= '0;
            end
        end
    end

    // table memory: one read port for the scan, one write at finish
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
            rd_entry_reg <= mem[idx];
        if (cmd.finish && res_write)
            mem[free_idx_reg] <= {key_reg, pages_reg, backer_reg};
    end

    assign rsp = rsp_reg;

`ifndef SYNTHESIS
    a_write_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && res_write) |-> (free_found_reg && !valid_reg[free_idx_reg]))
        else $error("region stored into an occupied slot");
`endif

endmodule
`default_nettype wire
